>>> design/llsf_pkg.sv
// Package for the least-squares line fit block.
// Holds the request/result types, controller commands and the product plan.
// No dependencies.
package llsf_pkg;

  // Fixed field width, product count and saturation limits
  localparam int unsigned PU_W        = 11;
  localparam int unsigned PROD_COUNT  = 6;
  localparam logic [32:0] SAT_POS     = 33'h0_7FFF_FFFF;
  localparam logic [32:0] SAT_NEG_MAG = 33'h0_8000_0000;

  typedef struct packed {
    logic signed [15:0] x_value;
    logic signed [15:0] y_value;
    logic               last_point;
  } point_t;

  typedef struct packed {
    logic signed [31:0] slope;
    logic signed [31:0] intercept;
    logic               degenerate;
    logic [PU_W-1:0]    points_used;
    logic               overflowed;
  } result_t;

  // Datapath commands issued by the controller
  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_MUL_LOAD,
    CMD_MUL_STEP,
    CMD_SAVE_A,
    CMD_SAVE_DIFF,
    CMD_DIV_LOAD,
    CMD_DIV_STEP,
    CMD_DIV_SAVE,
    CMD_EMIT
  } cmd_e;

  // Multiplier operand sources
  typedef enum logic [2:0] {
    OPD_N,
    OPD_SX,
    OPD_SY,
    OPD_SXX,
    OPD_SXY
  } opnd_e;

  // Difference registers: denominator, slope and intercept numerators
  typedef enum logic [1:0] {
    SLOT_DEN,
    SLOT_SNUM,
    SLOT_INUM
  } slot_e;

  typedef enum logic {
    QUOT_SLOPE,
    QUOT_ICEPT
  } quot_e;

  typedef struct packed {
    logic  accept;
    cmd_e  cmd;
    opnd_e opa;
    opnd_e opb;
    slot_e slot;
    quot_e quot_sel;
  } dp_cmd_t;

  typedef struct packed {
    opnd_e opa;
    opnd_e opb;
    slot_e slot;
  } plan_t;

  // Product schedule: each pair of products forms one difference
  function automatic plan_t prod_plan(logic [2:0] idx);
    plan_t p;
    case (idx)
      3'd0:    p = '{opa: OPD_N,  opb: OPD_SXX, slot: SLOT_DEN};
      3'd1:    p = '{opa: OPD_SX, opb: OPD_SX,  slot: SLOT_DEN};
      3'd2:    p = '{opa: OPD_N,  opb: OPD_SXY, slot: SLOT_SNUM};
      3'd3:    p = '{opa: OPD_SX, opb: OPD_SY,  slot: SLOT_SNUM};
      3'd4:    p = '{opa: OPD_SY, opb: OPD_SXX, slot: SLOT_INUM};
      3'd5:    p = '{opa: OPD_SX, opb: OPD_SXY, slot: SLOT_INUM};
      default: p = '{opa: OPD_N,  opb: OPD_N,   slot: SLOT_DEN};
    endcase
    return p;
  endfunction

endpackage

>>> design/linear_least_squares_fit_top.sv
// Least-squares line fit: one point per request, slope/intercept on the last one.
// A point that is not last leaves busy low; a last point raises busy while the bit-serial
// multiplier and divider work, and degenerate sets skip the divider.
// done_o pulses in the first cycle busy is low.
// Reset (rst_ni low, async) clears the sums, the count, the drop flag and the controller.
module linear_least_squares_fit_top #(
  parameter int unsigned MAX_POINTS = 1024
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  llsf_pkg::point_t  point_i,
  output logic              done_o,
  output llsf_pkg::result_t result_o
);

  llsf_pkg::dp_cmd_t cmd;
  logic              degenerate;

  // Sequence the fit
  llsf_ctrl #(
    .MAX_POINTS(MAX_POINTS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .last_i      (point_i.last_point),
    .degenerate_i(degenerate),
    .busy_o      (busy),
    .cmd_o       (cmd)
  );

  // Accumulate and compute
  llsf_dp #(
    .MAX_POINTS(MAX_POINTS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .point_i     (point_i),
    .degenerate_o(degenerate),
    .done_o      (done_o),
    .result_o    (result_o)
  );

endmodule

>>> design/llsf_ctrl.sv
// Controller for the least-squares line fit block.
// Sequences accumulation, six shift-add products and, unless the set is degenerate, two restoring divisions.
// Depends on llsf_pkg.
module llsf_ctrl #(
  parameter int unsigned MAX_POINTS = 1024
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              last_i,
  input  logic              degenerate_i,
  output logic              busy_o,
  output llsf_pkg::dp_cmd_t cmd_o
);

  localparam int unsigned LG   = $clog2(MAX_POINTS);
  localparam int unsigned MW   = 31 + LG;
  localparam int unsigned NW   = 2 * MW + 17;
  localparam int unsigned CNTW = $clog2(NW);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DRAIN,
    S_MLOAD,
    S_MSTEP,
    S_MSAVE,
    S_DCHK,
    S_DLOAD,
    S_DSTEP,
    S_DSAVE,
    S_EMIT
  } state_e;

  state_e                state_q;
  logic [2:0]            pi_q;
  logic [CNTW-1:0]       cnt_q;
  llsf_pkg::quot_e       qsel_q;
  llsf_pkg::plan_t       plan;

  assign plan   = llsf_pkg::prod_plan(pi_q);
  assign busy_o = (state_q != S_IDLE);

  // Decode datapath command from state
  always_comb begin
    cmd_o          = '0;
    cmd_o.cmd      = llsf_pkg::CMD_NONE;
    cmd_o.opa      = plan.opa;
    cmd_o.opb      = plan.opb;
    cmd_o.slot     = plan.slot;
    cmd_o.quot_sel = qsel_q;
    case (state_q)
      S_IDLE:  cmd_o.accept = start_i;
      S_MLOAD: cmd_o.cmd = llsf_pkg::CMD_MUL_LOAD;
      S_MSTEP: cmd_o.cmd = llsf_pkg::CMD_MUL_STEP;
      S_MSAVE: cmd_o.cmd = pi_q[0] ? llsf_pkg::CMD_SAVE_DIFF : llsf_pkg::CMD_SAVE_A;
      S_DLOAD: cmd_o.cmd = llsf_pkg::CMD_DIV_LOAD;
      S_DSTEP: cmd_o.cmd = llsf_pkg::CMD_DIV_STEP;
      S_DSAVE: cmd_o.cmd = llsf_pkg::CMD_DIV_SAVE;
      S_EMIT:  cmd_o.cmd = llsf_pkg::CMD_EMIT;
      default: cmd_o.cmd = llsf_pkg::CMD_NONE;
    endcase
  end

  // Hold state, product index, step count and quotient select
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pi_q    <= '0;
      cnt_q   <= '0;
      qsel_q  <= llsf_pkg::QUOT_SLOPE;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (start_i && last_i) begin
            state_q <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          pi_q    <= '0;
          state_q <= S_MLOAD;
        end
        S_MLOAD: begin
          cnt_q   <= '0;
          state_q <= S_MSTEP;
        end
        S_MSTEP: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CNTW'(MW - 1)) begin
            state_q <= S_MSAVE;
          end
        end
        S_MSAVE: begin
          pi_q <= pi_q + 1'b1;
          if (pi_q == 3'(llsf_pkg::PROD_COUNT - 1)) begin
            state_q <= S_DCHK;
          end else begin
            state_q <= S_MLOAD;
          end
        end
        S_DCHK: begin
          qsel_q  <= llsf_pkg::QUOT_SLOPE;
          state_q <= degenerate_i ? S_EMIT : S_DLOAD;
        end
        S_DLOAD: begin
          cnt_q   <= '0;
          state_q <= S_DSTEP;
        end
        S_DSTEP: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CNTW'(NW - 1)) begin
            state_q <= S_DSAVE;
          end
        end
        S_DSAVE: begin
          if (qsel_q == llsf_pkg::QUOT_SLOPE) begin
            qsel_q  <= llsf_pkg::QUOT_ICEPT;
            state_q <= S_DLOAD;
          end else begin
            state_q <= S_EMIT;
          end
        end
        S_EMIT: begin
          state_q <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> design/llsf_dp.sv
// Datapath for the least-squares line fit block.
// Running sums, a shared shift-add multiplier, a restoring divider, result register.
// Depends on llsf_pkg.
module llsf_dp #(
  parameter int unsigned MAX_POINTS = 1024
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  llsf_pkg::dp_cmd_t cmd_i,
  input  llsf_pkg::point_t  point_i,
  output logic              degenerate_o,
  output logic              done_o,
  output llsf_pkg::result_t result_o
);

  localparam int unsigned LG  = $clog2(MAX_POINTS);
  localparam int unsigned CW  = $clog2(MAX_POINTS + 1);
  localparam int unsigned SXW = 16 + LG;
  localparam int unsigned SQW = 32 + LG;
  localparam int unsigned MW  = SQW - 1;
  localparam int unsigned PW  = 2 * MW;
  localparam int unsigned SW  = PW + 2;
  localparam int unsigned NW  = SW - 1 + 16;
  localparam int unsigned RW  = SW;
  localparam int unsigned PU  = llsf_pkg::PU_W;

  // Accumulation: input stage and running sums
  logic [CW-1:0]         count_q;
  logic                  drop_q;
  logic                  st_vld_q;
  logic signed [15:0]    x_q, y_q;
  logic signed [31:0]    xx_q, xy_q;
  logic signed [31:0]    xx_d, xy_d;
  logic signed [SXW-1:0] sx_q, sy_q;
  logic signed [SQW-1:0] sxx_q, sxy_q;
  logic                  room;
  logic                  emit;
  logic [CW+PU-1:0]      count_ext;

  assign room = (count_q < CW'(MAX_POINTS));
  assign emit = (cmd_i.cmd == llsf_pkg::CMD_EMIT);
  assign xx_d = point_i.x_value * point_i.x_value;
  assign xy_d = point_i.x_value * point_i.y_value;

  // Count the point or mark it dropped; clear at set end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      drop_q   <= 1'b0;
      st_vld_q <= 1'b0;
    end else begin
      st_vld_q <= cmd_i.accept && room;
      if (emit) begin
        count_q <= '0;
        drop_q  <= 1'b0;
      end else if (cmd_i.accept) begin
        if (room) begin
          count_q <= count_q + 1'b1;
        end else begin
          drop_q <= 1'b1;
        end
      end
    end
  end

  // Register the point and its products
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      x_q  <= point_i.x_value;
      y_q  <= point_i.y_value;
      xx_q <= xx_d;
      xy_q <= xy_d;
    end
  end

  // Add the staged point into the sums
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sx_q  <= '0;
      sy_q  <= '0;
      sxx_q <= '0;
      sxy_q <= '0;
    end else if (emit) begin
      sx_q  <= '0;
      sy_q  <= '0;
      sxx_q <= '0;
      sxy_q <= '0;
    end else if (st_vld_q) begin
      sx_q  <= sx_q + {{LG{x_q[15]}}, x_q};
      sy_q  <= sy_q + {{LG{y_q[15]}}, y_q};
      sxx_q <= sxx_q + {{LG{xx_q[31]}}, xx_q};
      sxy_q <= sxy_q + {{LG{xy_q[31]}}, xy_q};
    end
  end

  // Operand select and sign/magnitude split
  logic signed [SQW-1:0] opa_v, opb_v, opa_n, opb_n;
  logic [MW-1:0]         opa_mag, opb_mag;

  always_comb begin
    case (cmd_i.opa)
      llsf_pkg::OPD_N:   opa_v = {{(SQW-CW){1'b0}}, count_q};
      llsf_pkg::OPD_SX:  opa_v = {{(SQW-SXW){sx_q[SXW-1]}}, sx_q};
      llsf_pkg::OPD_SY:  opa_v = {{(SQW-SXW){sy_q[SXW-1]}}, sy_q};
      llsf_pkg::OPD_SXX: opa_v = sxx_q;
      llsf_pkg::OPD_SXY: opa_v = sxy_q;
      default:           opa_v = '0;
    endcase
    case (cmd_i.opb)
      llsf_pkg::OPD_N:   opb_v = {{(SQW-CW){1'b0}}, count_q};
      llsf_pkg::OPD_SX:  opb_v = {{(SQW-SXW){sx_q[SXW-1]}}, sx_q};
      llsf_pkg::OPD_SY:  opb_v = {{(SQW-SXW){sy_q[SXW-1]}}, sy_q};
      llsf_pkg::OPD_SXX: opb_v = sxx_q;
      llsf_pkg::OPD_SXY: opb_v = sxy_q;
      default:           opb_v = '0;
    endcase
  end

  assign opa_n   = -opa_v;
  assign opb_n   = -opb_v;
  assign opa_mag = opa_v[SQW-1] ? opa_n[MW-1:0] : opa_v[MW-1:0];
  assign opb_mag = opb_v[SQW-1] ? opb_n[MW-1:0] : opb_v[MW-1:0];

  // Shift-add multiplier, one multiplier bit per step
  logic [MW-1:0]        mul_a_q;
  logic [PW-1:0]        mul_p_q;
  logic                 mul_neg_q;
  logic [MW:0]          mul_hi;
  logic signed [SW-1:0] prod_s, prod_v;

  assign mul_hi = {1'b0, mul_p_q[PW-1:MW]} + (mul_p_q[0] ? {1'b0, mul_a_q} : '0);
  assign prod_s = {2'b00, mul_p_q};
  assign prod_v = mul_neg_q ? -prod_s : prod_s;

  always_ff @(posedge clk_i) begin
    if (cmd_i.cmd == llsf_pkg::CMD_MUL_LOAD) begin
      mul_a_q   <= opa_mag;
      mul_p_q   <= {{MW{1'b0}}, opb_mag};
      mul_neg_q <= opa_v[SQW-1] ^ opb_v[SQW-1];
    end else if (cmd_i.cmd == llsf_pkg::CMD_MUL_STEP) begin
      mul_p_q <= {mul_hi, mul_p_q[MW-1:1]};
    end
  end

  // Hold first product of a pair, then store the difference
  logic signed [SW-1:0] pa_q, den_q, snum_q, inum_q, diff;

  assign diff = pa_q - prod_v;

  always_ff @(posedge clk_i) begin
    if (cmd_i.cmd == llsf_pkg::CMD_SAVE_A) begin
      pa_q <= prod_v;
    end
    if (cmd_i.cmd == llsf_pkg::CMD_SAVE_DIFF) begin
      case (cmd_i.slot)
        llsf_pkg::SLOT_DEN:  den_q  <= diff;
        llsf_pkg::SLOT_SNUM: snum_q <= diff;
        llsf_pkg::SLOT_INUM: inum_q <= diff;
        default:             pa_q   <= diff;
      endcase
    end
  end

  assign degenerate_o = den_q[SW-1] | (den_q == '0);

  // Restoring divider on magnitudes, one quotient bit per step
  logic signed [SW-1:0] num_v, num_n;
  logic [SW-2:0]        num_mag;
  logic [NW-1:0]        dvd_q;
  logic [RW-2:0]        rem_q;
  logic [RW-1:0]        rsh, den_ext, rdiff;
  logic                 ge;
  logic [32:0]          q_q;
  logic                 sticky_q;
  logic                 div_neg_q;
  logic [32:0]          limit, q_sat, q_sat_n;
  logic [31:0]          q_res;

  assign num_v   = (cmd_i.quot_sel == llsf_pkg::QUOT_ICEPT) ? inum_q : snum_q;
  assign num_n   = -num_v;
  assign num_mag = num_v[SW-1] ? num_n[SW-2:0] : num_v[SW-2:0];
  assign rsh     = {rem_q, dvd_q[NW-1]};
  assign den_ext = {1'b0, den_q[SW-2:0]};
  assign ge      = (rsh >= den_ext);
  assign rdiff   = rsh - den_ext;
  assign limit   = div_neg_q ? llsf_pkg::SAT_NEG_MAG : llsf_pkg::SAT_POS;
  assign q_sat   = (sticky_q || (q_q > limit)) ? limit : q_q;
  assign q_sat_n = -q_sat;
  assign q_res   = div_neg_q ? q_sat_n[31:0] : q_sat[31:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.cmd == llsf_pkg::CMD_DIV_LOAD) begin
      if (cmd_i.quot_sel == llsf_pkg::QUOT_ICEPT) begin
        dvd_q <= {8'h00, num_mag, 8'h00};
      end else begin
        dvd_q <= {num_mag, 16'h0000};
      end
      rem_q     <= '0;
      q_q       <= '0;
      sticky_q  <= 1'b0;
      div_neg_q <= num_v[SW-1];
    end else if (cmd_i.cmd == llsf_pkg::CMD_DIV_STEP) begin
      dvd_q    <= {dvd_q[NW-2:0], 1'b0};
      rem_q    <= ge ? rdiff[RW-2:0] : rsh[RW-2:0];
      q_q      <= {q_q[31:0], ge};
      sticky_q <= sticky_q | q_q[32];
    end
  end

  // Keep the saturated quotients
  logic signed [31:0] slope_q, icept_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.cmd == llsf_pkg::CMD_DIV_SAVE) begin
      if (cmd_i.quot_sel == llsf_pkg::QUOT_ICEPT) begin
        icept_q <= q_res;
      end else begin
        slope_q <= q_res;
      end
    end
  end

  // Load the result register and pulse the strobe
  logic              done_q;
  llsf_pkg::result_t result_q;

  assign count_ext = {{PU{1'b0}}, count_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      result_q.slope       <= degenerate_o ? '0 : slope_q;
      result_q.intercept   <= degenerate_o ? '0 : icept_q;
      result_q.degenerate  <= degenerate_o;
      result_q.points_used <= count_ext[PU-1:0];
      result_q.overflowed  <= drop_q;
    end
  end

  assign done_o   = done_q;
  assign result_o = result_q;

endmodule

>>> tb/linear_least_squares_fit_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the least-squares line fit top level.
// Depends on llsf_pkg and linear_least_squares_fit_top; predicts every fit internally.

module linear_least_squares_fit_top_tb;

  localparam int unsigned MAX_POINTS   = 1024;
  localparam int unsigned QUIET_LIMIT  = 5000;
  localparam int unsigned RANDOM_ITEMS = 200;
  localparam logic [127:0] Q16_MAX_POS = 128'h7FFF_FFFF;
  localparam logic [127:0] Q16_MAX_NEG = 128'h8000_0000;

  // Shapes of a random data set
  typedef enum int unsigned {
    SHAPE_WIDE,
    SHAPE_NARROW,
    SHAPE_LINE,
    SHAPE_VERTICAL
  } set_shape_e;

  logic              clk_i;
  logic              rst_ni;
  logic              start;
  logic              busy;
  logic              done_o;
  llsf_pkg::point_t  point_i;
  llsf_pkg::result_t result_o;

  // Expected fits, oldest first
  llsf_pkg::result_t fit_expected[$];
  llsf_pkg::result_t fit_want;
  int unsigned err_count    = 0;
  int unsigned quiet_cycles = 0;
  int unsigned sent_points  = 0;
  bit          burst_mode   = 1'b0;

  // Running sums of the current data set
  int unsigned acc_count   = 0;
  longint      acc_sx      = 0;
  longint      acc_sxx     = 0;
  longint      acc_sy      = 0;
  longint      acc_sxy     = 0;
  bit          acc_dropped = 1'b0;

  linear_least_squares_fit_top #(
    .MAX_POINTS(MAX_POINTS)
  ) uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .point_i (point_i),
    .done_o  (done_o),
    .result_o(result_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Truncate num * 2^shift / den toward zero, saturate to Q16.16
  function automatic logic [31:0] q16_quotient(logic signed [127:0] num, int unsigned shift,
                                               logic [127:0] den);
    logic [127:0] mag;
    logic [127:0] quo;
    mag = (num < 0) ? -num : num;
    quo = (mag << shift) / den;
    if (num < 0) begin
      if (quo > Q16_MAX_NEG) quo = Q16_MAX_NEG;
      quo = -quo;
    end else if (quo > Q16_MAX_POS) begin
      quo = Q16_MAX_POS;
    end
    return quo[31:0];
  endfunction

  // Fold one accepted point into the sums; queue the fit on a last point
  task automatic fold_point(llsf_pkg::point_t p);
    longint              x;
    longint              y;
    logic signed [127:0] n;
    logic signed [127:0] sx;
    logic signed [127:0] sy;
    logic signed [127:0] sxx;
    logic signed [127:0] sxy;
    logic signed [127:0] den;
    llsf_pkg::result_t   fit;
    x = p.x_value;
    y = p.y_value;
    if (acc_count < MAX_POINTS) begin
      acc_sx  += x;
      acc_sxx += x * x;
      acc_sy  += y;
      acc_sxy += x * y;
      acc_count++;
    end else begin
      acc_dropped = 1'b1;
    end
    if (p.last_point) begin
      n   = acc_count;
      sx  = acc_sx;
      sy  = acc_sy;
      sxx = acc_sxx;
      sxy = acc_sxy;
      den = n * sxx - sx * sx;
      fit = '0;
      if (den <= 0) begin
        fit.degenerate = 1'b1;
      end else begin
        fit.slope     = q16_quotient(n * sxy - sx * sy, 16, den);
        fit.intercept = q16_quotient(sy * sxx - sx * sxy, 8, den);
      end
      fit.points_used = acc_count[llsf_pkg::PU_W-1:0];
      fit.overflowed  = acc_dropped;
      fit_expected.push_back(fit);
      acc_count   = 0;
      acc_sx      = 0;
      acc_sxx     = 0;
      acc_sy      = 0;
      acc_sxy     = 0;
      acc_dropped = 1'b0;
    end
  endtask

  // Send one point request; start stays high so the next request may follow at once
  task automatic send_point(logic signed [15:0] x, logic signed [15:0] y, bit last);
    int unsigned      gap;
    llsf_pkg::point_t p;
    p.x_value    = x;
    p.y_value    = y;
    p.last_point = last;
    gap = burst_mode ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start   <= 1'b1;
    point_i <= p;
    do @(posedge clk_i); while (busy);
    sent_points++;
    fold_point(p);
  endtask

  // Drop start and wait until every expected fit has come out
  task automatic wait_results();
    start <= 1'b0;
    do @(posedge clk_i); while (fit_expected.size() != 0 || busy);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %h, actual %h", name, want, got);
      err_count++;
    end
  endtask

  // Compare each fit against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (fit_expected.size() == 0) begin
        $error("fit result with no request pending");
        err_count++;
      end else begin
        fit_want = fit_expected.pop_front();
        check_field("slope", fit_want.slope, result_o.slope);
        check_field("intercept", fit_want.intercept, result_o.intercept);
        check_field("degenerate", 32'(fit_want.degenerate), 32'(result_o.degenerate));
        check_field("points_used", 32'(fit_want.points_used), 32'(result_o.points_used));
        check_field("overflowed", 32'(fit_want.overflowed), 32'(result_o.overflowed));
      end
    end
  end

  // Watchdog: stop when no request and no result moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // One-point sets: always degenerate
  task automatic test_single_point();
    send_point(16'h1234, 16'hFFFB, 1'b1);
    send_point(16'h8000, 16'h7FFF, 1'b1);
    wait_results();
  endtask

  // Corners of the Q8.8 range
  task automatic test_extreme_values();
    send_point(16'h8000, 16'h7FFF, 1'b0);
    send_point(16'h7FFF, 16'h8000, 1'b0);
    send_point(16'h8000, 16'h8000, 1'b0);
    send_point(16'h7FFF, 16'h7FFF, 1'b1);
    wait_results();
  endtask

  // All x equal gives a zero denominator
  task automatic test_equal_abscissa();
    send_point(16'h0100, 16'h0000, 1'b0);
    send_point(16'h0100, 16'h0500, 1'b0);
    send_point(16'h0100, 16'hFA00, 1'b1);
    send_point(16'h0000, 16'h0000, 1'b0);
    send_point(16'h0000, 16'h0000, 1'b1);
    wait_results();
  endtask

  // Steep lines that drive the slope past both Q16.16 limits
  task automatic test_slope_saturation();
    send_point(16'h0000, 16'h8000, 1'b0);
    send_point(16'h0001, 16'h7FFF, 1'b1);
    send_point(16'h0000, 16'h7FFF, 1'b0);
    send_point(16'h0001, 16'h8000, 1'b1);
    wait_results();
  endtask

  // Points exactly on y = 2x + 1
  task automatic test_exact_line();
    send_point(16'h0100, 16'h0300, 1'b0);
    send_point(16'h0200, 16'h0500, 1'b0);
    send_point(16'hFF00, 16'hFF00, 1'b0);
    send_point(16'h0080, 16'h0200, 1'b1);
    wait_results();
  endtask

  // Fill to capacity and go past it, so that the last point itself is dropped
  task automatic test_capacity();
    for (int i = 0; i < MAX_POINTS + 2; i++) begin
      send_point(16'($urandom), 16'($urandom), i == MAX_POINTS + 1);
    end
    wait_results();
  endtask

  // Random data sets of mostly small size and varied shape
  task automatic test_random_sets();
    int unsigned first_point;
    int unsigned set_size;
    set_shape_e  shape;
    int          k;
    int          b;
    int          xi;
    int          yi;
    int          x_fix;
    first_point = sent_points;
    while (sent_points - first_point < RANDOM_ITEMS) begin
      case ($urandom_range(0, 19))
        0:       set_size = 1;
        1, 2:    set_size = $urandom_range(13, 60);
        default: set_size = $urandom_range(2, 12);
      endcase
      shape      = set_shape_e'($urandom_range(0, 3));
      burst_mode = ($urandom_range(0, 3) == 0);
      k          = $urandom_range(0, 8) - 4;
      b          = $urandom_range(0, 4095) - 2048;
      x_fix      = $urandom;
      for (int i = 0; i < set_size; i++) begin
        case (shape)
          SHAPE_WIDE: begin
            xi = $urandom;
            yi = $urandom;
          end
          SHAPE_NARROW: begin
            xi = $urandom_range(0, 1023) - 512;
            yi = $urandom_range(0, 1023) - 512;
          end
          SHAPE_LINE: begin
            xi = $urandom_range(0, 2047) - 1024;
            yi = k * xi + b + $urandom_range(0, 15) - 8;
          end
          default: begin
            xi = x_fix;
            yi = $urandom;
          end
        endcase
        send_point(xi[15:0], yi[15:0], i == set_size - 1);
      end
    end
    burst_mode = 1'b0;
    wait_results();
  endtask

  initial begin
    rst_ni  = 1'b0;
    start   = 1'b0;
    point_i = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_single_point();
    test_extreme_values();
    test_equal_abscissa();
    test_slope_saturation();
    test_exact_line();
    test_capacity();
    test_random_sets();
    if (err_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> sim.f
design/llsf_pkg.sv
design/llsf_ctrl.sv
design/llsf_dp.sv
design/linear_least_squares_fit_top.sv
tb/linear_least_squares_fit_top_tb.sv
